// ===== rtl/mstu_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer unit package
// Shared constants, request and result types and state encodings for the
// multi-slot timer unit.
// ----------------------------------------------------------------------------
package mstu_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int MAX_EVENTS  = 16;
	localparam int SLOT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int WALK_W      = $clog2(NUM_TIMERS + 1);
	localparam int EVT_W       = $clog2(MAX_EVENTS + 1);
	localparam int ID_W        = 4;
	localparam int MS_W        = 16;
	// Queue depth must stay a power of two so the pointers wrap on their own.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_SET   = 2'd1,
		REQ_KILL  = 2'd2,
		REQ_QUERY = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		RESP_SET_OK     = 3'd0,
		RESP_FULL       = 3'd1,
		RESP_REMAINING  = 3'd2,
		RESP_NOT_ACTIVE = 3'd3,
		RESP_EXPIRY     = 3'd4
	} resp_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_QUERY,
		BK_WALK,
		BK_DRAIN
	} back_state_t;

	// One classified request as it travels through the queue.
	typedef struct packed {
		req_type_t       kind;
		logic [ID_W-1:0] id;
		logic            id_ok;
		logic [MS_W-1:0] period;
		logic            shot;
	} req_t;

	// Head of the request queue as seen by the back end.
	typedef struct packed {
		logic valid;
		req_t req;
	} queue_head_t;

	// Per-slot payload held in the slot memory.
	typedef struct packed {
		logic            shot;
		logic [MS_W-1:0] period;
		logic [MS_W-1:0] left;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	typedef struct packed {
		logic            valid;
		resp_kind_t      kind;
		logic [ID_W-1:0] slot;
		logic [MS_W-1:0] rem;
		logic            last;
	} result_t;

endpackage

// ===== rtl/mstu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module mstu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/mstu_front.sv =====
// ----------------------------------------------------------------------------
// Timer unit front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mstu_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [mstu_pkg::ID_W-1:0]   timer_id,
	input  logic [mstu_pkg::MS_W-1:0]   period_ms,
	input  logic                        single_shot,
	output mstu_pkg::queue_head_t       head,
	input  logic                        pop
);

	mstu_pkg::req_t                     q_mem_q [mstu_pkg::QUEUE_DEPTH];
	logic [mstu_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [mstu_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [mstu_pkg::QCNT_W-1:0]        cnt_q;
	logic                               push;
	mstu_pkg::req_t                     req_in;

	assign busy = (cnt_q == mstu_pkg::QCNT_W'(mstu_pkg::QUEUE_DEPTH));
	assign push = start && !busy;

	// Classification: decode the kind and check the slot id against the table.
	always_comb begin
		req_in.kind   = mstu_pkg::req_type_t'(req_type);
		req_in.id     = timer_id;
		req_in.id_ok  = (32'(timer_id) < mstu_pkg::NUM_TIMERS);
		req_in.period = period_ms;
		req_in.shot   = single_shot;
	end

	assign head.valid = (cnt_q != '0);
	assign head.req   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mstu_back.sv =====
// ----------------------------------------------------------------------------
// Timer unit back end
// Executes queued requests against the slot table and produces results.
// ----------------------------------------------------------------------------
module mstu_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mstu_pkg::queue_head_t head,
	output logic                  pop,
	output mstu_pkg::result_t     result
);

	localparam int SW  = mstu_pkg::SLOT_W;
	localparam int WW  = mstu_pkg::WALK_W;
	localparam int EW  = mstu_pkg::EVT_W;
	localparam int IDW = mstu_pkg::ID_W;
	localparam int MW  = mstu_pkg::MS_W;
	localparam int N   = mstu_pkg::NUM_TIMERS;

	mstu_pkg::back_state_t  state_q, state_d;
	logic [WW-1:0]          rd_idx_q, rd_idx_d;
	logic                   vld_s1, vld_d;
	logic [SW-1:0]          idx_s1, idx_d;
	logic                   pend_vld_q, pend_vld_d;
	logic [SW-1:0]          pend_slot_q, pend_slot_d;
	logic [EW-1:0]          ev_cnt_q, ev_cnt_d;
	logic [N-1:0]           active_q, active_d;
	logic [N-1:0]           fresh_q, fresh_d;
	logic [IDW-1:0]         q_id_q, q_id_d;
	logic                   q_hit_q, q_hit_d;
	mstu_pkg::result_t      res_q, res_d;

	logic                   ram_we;
	logic [SW-1:0]          ram_waddr;
	mstu_pkg::slot_entry_t  ram_wdata;
	logic                   ram_re;
	logic [SW-1:0]          ram_raddr;
	logic [mstu_pkg::ENTRY_W-1:0] ram_rdata;
	mstu_pkg::slot_entry_t  rd;

	logic                   free_found;
	logic [SW-1:0]          free_idx;
	logic [SW-1:0]          head_idx;
	logic [MW-1:0]          cnt_src;
	logic [MW-1:0]          cnt_dec;
	logic [MW-1:0]          set_left;

	mstu_ram #(
		.WIDTH(mstu_pkg::ENTRY_W),
		.DEPTH(N)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd       = ram_rdata;
	assign head_idx = SW'(head.req.id);
	assign set_left = (head.req.period != '0) ? head.req.period - 1'b1 : '0;
	assign result   = res_q;

	// Lowest free slot.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// Countdown of the slot whose entry has just come out of the memory.
	assign cnt_src = fresh_q[idx_s1] ? rd.period : rd.left;
	assign cnt_dec = (cnt_src != '0) ? cnt_src - 1'b1 : '0;

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		rd_idx_d    = rd_idx_q;
		vld_d       = 1'b0;
		idx_d       = idx_s1;
		pend_vld_d  = pend_vld_q;
		pend_slot_d = pend_slot_q;
		ev_cnt_d    = ev_cnt_q;
		active_d    = active_q;
		fresh_d     = fresh_q;
		q_id_d      = q_id_q;
		q_hit_d     = q_hit_q;
		res_d       = '0;
		ram_we      = 1'b0;
		ram_waddr   = idx_s1;
		ram_wdata   = rd;
		ram_re      = 1'b0;
		ram_raddr   = '0;

		unique case (state_q)
			mstu_pkg::BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.req.kind)
						mstu_pkg::REQ_TICK: begin
							rd_idx_d   = '0;
							pend_vld_d = 1'b0;
							ev_cnt_d   = '0;
							state_d    = mstu_pkg::BK_WALK;
						end
						mstu_pkg::REQ_SET: begin
							res_d.valid = 1'b1;
							res_d.last  = 1'b1;
							if (free_found) begin
								ram_we             = 1'b1;
								ram_waddr          = free_idx;
								ram_wdata.shot     = head.req.shot;
								ram_wdata.period   = head.req.period;
								ram_wdata.left     = set_left;
								active_d[free_idx] = 1'b1;
								fresh_d[free_idx]  = 1'b1;
								res_d.kind         = mstu_pkg::RESP_SET_OK;
								res_d.slot         = IDW'(free_idx);
							end else begin
								res_d.kind = mstu_pkg::RESP_FULL;
							end
						end
						mstu_pkg::REQ_KILL: begin
							if (head.req.id_ok) begin
								active_d[head_idx] = 1'b0;
							end
						end
						mstu_pkg::REQ_QUERY: begin
							ram_re    = 1'b1;
							ram_raddr = head_idx;
							q_id_d    = head.req.id;
							q_hit_d   = head.req.id_ok && active_q[head_idx];
							state_d   = mstu_pkg::BK_QUERY;
						end
						default: begin
						end
					endcase
				end
			end
			mstu_pkg::BK_QUERY: begin
				res_d.valid = 1'b1;
				res_d.last  = 1'b1;
				res_d.slot  = q_id_q;
				if (q_hit_q) begin
					res_d.kind = mstu_pkg::RESP_REMAINING;
					res_d.rem  = rd.left;
				end else begin
					res_d.kind = mstu_pkg::RESP_NOT_ACTIVE;
				end
				state_d = mstu_pkg::BK_IDLE;
			end
			mstu_pkg::BK_WALK: begin
				if (rd_idx_q != WW'(N)) begin
					ram_re    = 1'b1;
					ram_raddr = rd_idx_q[SW-1:0];
					vld_d     = 1'b1;
					idx_d     = rd_idx_q[SW-1:0];
					rd_idx_d  = rd_idx_q + 1'b1;
				end else begin
					state_d = mstu_pkg::BK_DRAIN;
				end
			end
			mstu_pkg::BK_DRAIN: begin
				if (pend_vld_q) begin
					res_d.valid = 1'b1;
					res_d.kind  = mstu_pkg::RESP_EXPIRY;
					res_d.slot  = IDW'(pend_slot_q);
					res_d.last  = 1'b1;
				end
				pend_vld_d = 1'b0;
				state_d    = mstu_pkg::BK_IDLE;
			end
			default: begin
				state_d = mstu_pkg::BK_IDLE;
			end
		endcase

		// Tick walk, second stage: count down and write back one slot. An
		// expiry is held back one event so the final one can carry last.
		if (vld_s1 && active_q[idx_s1]) begin
			ram_we          = 1'b1;
			ram_waddr       = idx_s1;
			ram_wdata.left  = cnt_dec;
			fresh_d[idx_s1] = 1'b0;
			if (cnt_dec == '0) begin
				if (rd.shot) begin
					active_d[idx_s1] = 1'b0;
				end else begin
					fresh_d[idx_s1] = 1'b1;
				end
				if (ev_cnt_q < EW'(mstu_pkg::MAX_EVENTS)) begin
					if (pend_vld_q) begin
						res_d.valid = 1'b1;
						res_d.kind  = mstu_pkg::RESP_EXPIRY;
						res_d.slot  = IDW'(pend_slot_q);
						res_d.last  = 1'b0;
					end
					pend_vld_d  = 1'b1;
					pend_slot_d = idx_s1;
					ev_cnt_d    = ev_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mstu_pkg::BK_IDLE;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			pend_vld_q  <= 1'b0;
			pend_slot_q <= '0;
			ev_cnt_q    <= '0;
			active_q    <= '0;
			fresh_q     <= '0;
			q_id_q      <= '0;
			q_hit_q     <= 1'b0;
			res_q       <= '0;
		end else begin
			state_q     <= state_d;
			rd_idx_q    <= rd_idx_d;
			vld_s1      <= vld_d;
			idx_s1      <= idx_d;
			pend_vld_q  <= pend_vld_d;
			pend_slot_q <= pend_slot_d;
			ev_cnt_q    <= ev_cnt_d;
			active_q    <= active_d;
			fresh_q     <= fresh_d;
			q_id_q      <= q_id_d;
			q_hit_q     <= q_hit_d;
			res_q       <= res_d;
		end
	end

	// Set and query answers are always the only result of their request.
	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid && res_q.kind != mstu_pkg::RESP_EXPIRY |-> res_q.last)
		else $error("set or query result without last");

	// A held expiry is flushed as the final event of the tick.
	a_drain_flush: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mstu_pkg::BK_DRAIN && pend_vld_q |=> res_q.valid && res_q.last)
		else $error("pending expiry not flushed with last");

	// Expiry events come only from the tick walk.
	a_expiry_origin: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid && res_q.kind == mstu_pkg::RESP_EXPIRY |->
		$past(state_q) == mstu_pkg::BK_WALK || $past(state_q) == mstu_pkg::BK_DRAIN)
		else $error("expiry event outside a tick");

	// A query never alters the slot table.
	a_query_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mstu_pkg::BK_QUERY |=> $stable(active_q) && $stable(fresh_q))
		else $error("slot state changed during query");

endmodule

// ===== rtl/multi_slot_software_timer_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-slot software timer unit
// Table of millisecond timer slots with set, kill, query and tick requests.
// ----------------------------------------------------------------------------
// Path: a set result passes the queue and then the result register; a
// query result passes the queue, the BK_QUERY memory read and the result
// register; a kill gives no result. The back end finishes each request
// before it pops the next, and a tick walks the slot memory one slot per cycle.
// Reset clears all slots to inactive at once; the receiver cannot stall.
module multi_slot_software_timer_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic [mstu_pkg::ID_W-1:0] timer_id,
	input  logic [mstu_pkg::MS_W-1:0] period_ms,
	input  logic                      single_shot,
	output logic                      strobe,
	output logic [2:0]                resp_kind,
	output logic [mstu_pkg::ID_W-1:0] slot_id,
	output logic [mstu_pkg::MS_W-1:0] remaining_ms,
	output logic                      last
);

	// The front end takes an item whenever its two-entry queue has room, so
	// the caller can post the next request while a tick walk is still running.
	mstu_pkg::queue_head_t head;
	logic                  pop;
	mstu_pkg::result_t     result;

	mstu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.timer_id   (timer_id),
		.period_ms  (period_ms),
		.single_shot(single_shot),
		.head       (head),
		.pop        (pop)
	);

	// The back end owns the slot table: active and fresh flags live in
	// flip-flops, while the period, remaining count and single-shot flag of
	// each slot live in a small memory. A tick streams through that memory,
	// reading one slot and writing back the previous one every cycle.
	mstu_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.result(result)
	);

	// Results come straight from the back end's output register; each one is
	// on the ports for a single cycle.
	assign strobe       = result.valid;
	assign resp_kind    = result.kind;
	assign slot_id      = result.slot;
	assign remaining_ms = result.rem;
	assign last         = result.last;

endmodule
